// ----- design/bus_address_decoder_page_mapper_macros.svh -----
// ----------------------------------------------------------------------------
// Bus address decoder page mapper: assertion macros
// Shared implication forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BUS_ADDRESS_DECODER_PAGE_MAPPER_MACROS_SVH
`define BUS_ADDRESS_DECODER_PAGE_MAPPER_MACROS_SVH

// same-cycle implication, disabled in reset
`define BAPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bapm assertion failed");

// next-cycle implication, disabled in reset
`define BAPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bapm assertion failed");

`endif

// ----- design/bapm_pkg.sv -----
// ----------------------------------------------------------------------------
// Bus address decoder page mapper: package
// Request codes, target codes, decode constants and the page table write type.
// ----------------------------------------------------------------------------
`default_nettype none

package bapm_pkg;

    localparam int PAGE_ENTRIES = 16;
    localparam int PT_IDX_W     = $clog2(PAGE_ENTRIES);
    localparam int PT_DATA_W    = 8;

    localparam logic [1:0] REQ_MEM_RD  = 2'd0;
    localparam logic [1:0] REQ_MEM_WR  = 2'd1;
    localparam logic [1:0] REQ_LINE_WR = 2'd2;
    localparam logic [1:0] REQ_LINE_RD = 2'd3;

    localparam logic [3:0] TGT_NONE    = 4'd0;
    localparam logic [3:0] TGT_ROM0    = 4'd1;
    localparam logic [3:0] TGT_DSR     = 4'd2;
    localparam logic [3:0] TGT_ROM6A   = 4'd3;
    localparam logic [3:0] TGT_ROM6B   = 4'd4;
    localparam logic [3:0] TGT_RAM     = 4'd5;
    localparam logic [3:0] TGT_SCRATCH = 4'd6;
    localparam logic [3:0] TGT_SOUND   = 4'd7;
    localparam logic [3:0] TGT_VIDEO   = 4'd8;
    localparam logic [3:0] TGT_MAPREG  = 4'd9;
    localparam logic [3:0] TGT_PERIPH  = 4'd10;
    localparam logic [3:0] TGT_PLINE   = 4'd11;
    localparam logic [3:0] TGT_SELA    = 4'd12;
    localparam logic [3:0] TGT_SELB    = 4'd13;

    localparam logic [2:0] ZONE_ROM0 = 3'b000;
    localparam logic [2:0] ZONE_RAM1 = 3'b001;
    localparam logic [2:0] ZONE_DSR  = 3'b010;
    localparam logic [2:0] ZONE_ROM6 = 3'b011;
    localparam logic [2:0] ZONE_IO   = 3'b100;
    localparam logic [2:0] ZONE_RAM5 = 3'b101;
    localparam logic [2:0] ZONE_RAM6 = 3'b110;
    localparam logic [2:0] ZONE_RAM7 = 3'b111;

    localparam logic [7:0]  LINE_SYS_PAGE  = 8'h0f;
    localparam logic [7:0]  LINE_MAP_PAGE  = 8'h1e;
    localparam logic [2:0]  LBIT_DSR       = 3'd0;
    localparam logic [2:0]  LBIT_ROM6      = 3'd1;
    localparam logic [2:0]  LBIT_SELA      = 3'd2;
    localparam logic [2:0]  LBIT_SELB      = 3'd3;
    localparam logic [2:0]  LBIT_MAPACC    = 3'd0;
    localparam logic [2:0]  LBIT_MAPEN     = 3'd1;

    localparam logic [15:0] MAPREG_MASK    = 16'hffe0;
    localparam logic [15:0] MAPREG_BASE    = 16'h4000;
    localparam logic [15:0] SOUND_MASK     = 16'hfff0;
    localparam logic [15:0] SOUND_BASE     = 16'h8400;
    localparam logic [15:0] SCRATCH_MASK   = 16'hfc00;
    localparam logic [15:0] SCRATCH_BASE   = 16'h8000;
    localparam logic [15:0] VIDEO_MASK     = 16'hfffd;
    localparam logic [15:0] VIDEO_RD_BASE  = 16'h8800;
    localparam logic [15:0] VIDEO_WR_BASE  = 16'h8c00;

    localparam logic [1:0]  LANES_NONE = 2'b00;
    localparam logic [1:0]  LANES_LOW  = 2'b01;
    localparam logic [1:0]  LANES_HIGH = 2'b10;
    localparam logic [1:0]  LANES_BOTH = 2'b11;

    typedef struct packed {
        logic                 en;
        logic [PT_IDX_W-1:0]  idx;
        logic [PT_DATA_W-1:0] data;
    } t_pt_wr;

endpackage

`default_nettype wire

// ----- design/bapm_page_mem.sv -----
// ----------------------------------------------------------------------------
// Bus address decoder page mapper: page table memory
// Sixteen page registers in a synchronous memory, with per-entry
// valid bits for the zero reset and write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module bapm_page_mem
    import bapm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rd_en,
    input  wire logic [PT_IDX_W-1:0]  i_rd_idx,
    input  wire t_pt_wr               i_wr,
    output logic      [PT_DATA_W-1:0] o_rd_data
);

    logic [PT_DATA_W-1:0]    r_mem [PAGE_ENTRIES];
    logic [PAGE_ENTRIES-1:0] r_valid;
    logic [PT_DATA_W-1:0]    r_q;
    logic [PT_DATA_W-1:0]    r_fwd_data;
    logic                    r_fwd_hit;
    logic                    r_q_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_idx];
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_fwd_hit <= 1'b0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_fwd_hit <= i_wr.en && (i_wr.idx == i_rd_idx);
                r_q_valid <= r_valid[i_rd_idx];
            end
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : (r_q_valid ? r_q : '0);

endmodule

`default_nettype wire

// ----- design/bus_address_decoder_page_mapper.sv -----
// ----------------------------------------------------------------------------
// Bus address decoder page mapper
// Decodes one bus access per word into a target, translated address, merged
// data and byte lanes; keeps enable flags, page table and peripheral latches.
// ----------------------------------------------------------------------------
// Takes one access word per cycle while the output is not stalled and returns
// one result word for each. An accepted word reads the page table (synchronous
// memory) at the edge it is taken, is decoded in the next cycle against the
// flags, and lands in the output register once the output stage can take it.
// Page table writes from mapper register accesses are forwarded to a
// following read of the same entry. No clearing pass is needed after reset.
`default_nettype none

module bus_address_decoder_page_mapper
    import bapm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_bus_address,
    input  wire logic [15:0] i_write_word,
    input  wire logic [1:0]  i_lane_enable,
    input  wire logic        i_line_value,
    input  wire logic [15:0] i_periph_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_target,
    output logic [19:0]      o_target_address,
    output logic             o_is_write,
    output logic [15:0]      o_data_word,
    output logic             o_data_from_block,
    output logic [1:0]       o_lanes_out
);

    logic        r_s1_valid;
    logic [1:0]  r_req;
    logic [15:0] r_addr;
    logic [15:0] r_wd;
    logic [1:0]  r_lanes;
    logic        r_lv;
    logic [15:0] r_pw;

    logic r_dsr_en, r_rom6_en, r_bank_sel, r_map_en, r_mapreg_acc;
    logic n_dsr_en, n_rom6_en, n_bank_sel, n_map_en, n_mapreg_acc;
    logic [7:0] r_low_latch, r_high_latch, n_low_latch, n_high_latch;

    logic        r_out_valid;
    logic [3:0]  r_target,      n_target;
    logic [19:0] r_taddr,       n_taddr;
    logic        r_is_write,    n_is_write;
    logic [15:0] r_data,        n_data;
    logic        r_from_blk,    n_from_blk;
    logic [1:0]  r_lanes_out,   n_lanes_out;

    logic                 accept;
    logic                 s1_adv;
    logic [PT_IDX_W-1:0]  rd_idx;
    logic [PT_DATA_W-1:0] pt_q;
    t_pt_wr               pt_wr;

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign accept  = i_valid && o_ready;
    assign rd_idx  = (i_bus_address[15:13] == ZONE_DSR) ? i_bus_address[PT_IDX_W:1]
                                                        : i_bus_address[15 -: PT_IDX_W];

    bapm_page_mem u_page_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_idx  (rd_idx),
        .i_wr      (pt_wr),
        .o_rd_data (pt_q)
    );

    always_comb begin
        logic [15:0] a;
        logic        wr;
        logic        done;
        logic [7:0]  new_entry;
        a            = {r_addr[15:1], 1'b0};
        wr           = (r_req == REQ_MEM_WR);
        done         = 1'b0;
        new_entry    = r_lanes[0] ? r_wd[7:0] : pt_q;
        n_target     = TGT_NONE;
        n_taddr      = '0;
        n_is_write   = 1'b0;
        n_data       = '0;
        n_from_blk   = 1'b0;
        n_lanes_out  = LANES_NONE;
        n_dsr_en     = r_dsr_en;
        n_rom6_en    = r_rom6_en;
        n_bank_sel   = r_bank_sel;
        n_map_en     = r_map_en;
        n_mapreg_acc = r_mapreg_acc;
        n_low_latch  = r_low_latch;
        n_high_latch = r_high_latch;
        pt_wr        = '0;
        pt_wr.idx    = a[PT_IDX_W:1];
        pt_wr.data   = r_wd[7:0];
        case (r_req)
            REQ_LINE_WR: begin
                if (r_addr[15:8] == LINE_SYS_PAGE) begin
                    case (r_addr[3:1])
                        LBIT_DSR:  n_dsr_en  = r_lv;
                        LBIT_ROM6: n_rom6_en = r_lv;
                        LBIT_SELA, LBIT_SELB: begin
                            n_target   = (r_addr[3:1] == LBIT_SELA) ? TGT_SELA : TGT_SELB;
                            n_taddr    = {4'd0, r_addr};
                            n_is_write = 1'b1;
                            n_data     = {15'd0, r_lv};
                        end
                        default: ;
                    endcase
                end else if (r_addr[15:8] == LINE_MAP_PAGE) begin
                    case (r_addr[3:1])
                        LBIT_MAPACC: n_mapreg_acc = r_lv;
                        LBIT_MAPEN:  n_map_en     = r_lv;
                        default: ;
                    endcase
                end else begin
                    n_target   = TGT_PLINE;
                    n_taddr    = {4'd0, r_addr};
                    n_is_write = 1'b1;
                    n_data     = {15'd0, r_lv};
                end
            end
            REQ_LINE_RD: begin
                n_target = TGT_PLINE;
                n_taddr  = {4'd0, r_addr};
            end
            default: begin
                case (a[15:13])
                    ZONE_ROM0: begin
                        done = 1'b1;
                        if (!wr) begin
                            n_target    = TGT_ROM0;
                            n_taddr     = {7'd0, a[12:0]};
                            n_lanes_out = r_lanes;
                        end
                    end
                    ZONE_RAM1, ZONE_RAM5, ZONE_RAM6, ZONE_RAM7: begin
                        done        = 1'b1;
                        n_target    = TGT_RAM;
                        n_taddr     = r_map_en ? {pt_q, a[11:0]} : {4'd0, a};
                        n_is_write  = wr;
                        n_data      = wr ? r_wd : 16'd0;
                        n_lanes_out = r_lanes;
                    end
                    ZONE_DSR: begin
                        if (r_dsr_en) begin
                            done = 1'b1;
                            if (!wr) begin
                                n_target    = TGT_DSR;
                                n_taddr     = {7'd0, a[12:0]};
                                n_lanes_out = r_lanes;
                            end
                        end else if (r_mapreg_acc && ((a & MAPREG_MASK) == MAPREG_BASE)) begin
                            done        = 1'b1;
                            n_target    = TGT_MAPREG;
                            n_taddr     = {{(20-PT_IDX_W){1'b0}}, a[PT_IDX_W:1]};
                            n_lanes_out = r_lanes;
                            if (wr) begin
                                pt_wr.en   = s1_adv && r_lanes[0];
                                n_is_write = 1'b1;
                                n_data     = {8'd0, new_entry};
                            end else begin
                                n_data     = {pt_q, 8'd0};
                                n_from_blk = 1'b1;
                            end
                        end
                    end
                    ZONE_ROM6: begin
                        if (r_rom6_en) begin
                            done = 1'b1;
                            if (wr) begin
                                n_bank_sel = a[1];
                                n_target   = a[1] ? TGT_ROM6B : TGT_ROM6A;
                            end else begin
                                n_target    = r_bank_sel ? TGT_ROM6B : TGT_ROM6A;
                                n_taddr     = {7'd0, a[12:0]};
                                n_lanes_out = r_lanes;
                            end
                        end
                    end
                    ZONE_IO: begin
                        if ((a & SOUND_MASK) == SOUND_BASE) begin
                            done       = 1'b1;
                            n_target   = TGT_SOUND;
                            n_is_write = wr;
                            if (wr) begin
                                n_data      = {8'd0, r_wd[15:8]};
                                n_lanes_out = LANES_HIGH;
                            end else begin
                                n_from_blk  = 1'b1;
                                n_lanes_out = r_lanes;
                            end
                        end else if ((a & SCRATCH_MASK) == SCRATCH_BASE) begin
                            done        = 1'b1;
                            n_target    = TGT_SCRATCH;
                            n_taddr     = {10'd0, a[9:0]};
                            n_is_write  = wr;
                            n_data      = wr ? r_wd : 16'd0;
                            n_lanes_out = r_lanes;
                        end else if ((a & VIDEO_MASK) == (wr ? VIDEO_WR_BASE : VIDEO_RD_BASE)) begin
                            done        = 1'b1;
                            n_target    = TGT_VIDEO;
                            n_taddr     = {18'd0, a[1], 1'b0};
                            n_is_write  = wr;
                            n_data      = wr ? r_wd : 16'd0;
                            n_lanes_out = r_lanes;
                        end
                    end
                    default: ;
                endcase
                if (!done) begin
                    n_target = TGT_PERIPH;
                    n_taddr  = {4'd0, a};
                    if (wr) begin
                        n_is_write  = 1'b1;
                        n_lanes_out = LANES_BOTH;
                        case (r_lanes)
                            LANES_HIGH: n_data = {r_wd[15:8], r_low_latch};
                            LANES_LOW:  n_data = {r_high_latch, r_wd[7:0]};
                            default:    n_data = r_wd;
                        endcase
                    end else begin
                        n_low_latch  = r_pw[7:0];
                        n_high_latch = r_pw[15:8];
                        n_data       = r_pw;
                        n_from_blk   = 1'b1;
                        n_lanes_out  = r_lanes;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_req_type;
            r_addr  <= i_bus_address;
            r_wd    <= i_write_word;
            r_lanes <= i_lane_enable;
            r_lv    <= i_line_value;
            r_pw    <= i_periph_word;
        end
        if (s1_adv) begin
            r_target    <= n_target;
            r_taddr     <= n_taddr;
            r_is_write  <= n_is_write;
            r_data      <= n_data;
            r_from_blk  <= n_from_blk;
            r_lanes_out <= n_lanes_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_dsr_en     <= 1'b0;
            r_rom6_en    <= 1'b0;
            r_bank_sel   <= 1'b0;
            r_map_en     <= 1'b0;
            r_mapreg_acc <= 1'b0;
            r_low_latch  <= '0;
            r_high_latch <= '0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_adv) begin
                r_out_valid  <= 1'b1;
                r_dsr_en     <= n_dsr_en;
                r_rom6_en    <= n_rom6_en;
                r_bank_sel   <= n_bank_sel;
                r_map_en     <= n_map_en;
                r_mapreg_acc <= n_mapreg_acc;
                r_low_latch  <= n_low_latch;
                r_high_latch <= n_high_latch;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_target          = r_target;
    assign o_target_address  = r_taddr;
    assign o_is_write        = r_is_write;
    assign o_data_word       = r_data;
    assign o_data_from_block = r_from_blk;
    assign o_lanes_out       = r_lanes_out;

endmodule

`default_nettype wire

// ----- design/bapm_checker.sv -----
// ----------------------------------------------------------------------------
// Bus address decoder page mapper: port checker
// Watches the top level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bus_address_decoder_page_mapper_macros.svh"

module bapm_checker
    import bapm_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [3:0]  o_target,
    input wire logic [19:0] o_target_address,
    input wire logic        o_is_write,
    input wire logic [15:0] o_data_word,
    input wire logic        o_data_from_block,
    input wire logic [1:0]  o_lanes_out
);

    `BAPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_target) && $stable(o_target_address) && $stable(o_data_word))
    `BAPM_ASSERT_NOW(a_none_quiet, i_clk, i_rst_n, o_valid && (o_target == TGT_NONE), !o_is_write && (o_target_address == 20'd0) && (o_data_word == 16'd0) && (o_lanes_out == LANES_NONE))
    `BAPM_ASSERT_NOW(a_answer_is_read, i_clk, i_rst_n, o_valid && o_data_from_block, !o_is_write)
    `BAPM_ASSERT_NOW(a_sound_write, i_clk, i_rst_n, o_valid && (o_target == TGT_SOUND) && o_is_write, (o_lanes_out == LANES_HIGH) && (o_data_word[15:8] == 8'd0))

endmodule

bind bus_address_decoder_page_mapper bapm_checker u_bapm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_target          (o_target),
    .o_target_address  (o_target_address),
    .o_is_write        (o_is_write),
    .o_data_word       (o_data_word),
    .o_data_from_block (o_data_from_block),
    .o_lanes_out       (o_lanes_out)
);

`default_nettype wire
